// File: hw/rtl/pid_drive_controller_assert.svh
// Assertion macros used by pdc_err.
`ifndef PID_DRIVE_CONTROLLER_ASSERT_SVH
`define PID_DRIVE_CONTROLLER_ASSERT_SVH

// Clocking and reset qualifier used by every checked property.
`define PDC_CLK_RST(clk, rst) @(posedge clk) disable iff (rst)

// Concurrent assertion, disabled while reset is high.
`define PDC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (`PDC_CLK_RST(clk, rst) prop) else $error(msg);

`endif

// File: hw/rtl/pdc_pkg.sv
`default_nettype none

package pdc_pkg;

   localparam int GAIN_W   = 24;
   localparam int FIELD_W  = 16;
   localparam int ERR_W    = 16;
   localparam int DERIV_W  = ERR_W + 1;
   localparam int SUM_W    = 32;
   localparam int DRIVE_W  = 8;
   localparam int Q_SHIFT  = 16;
   localparam int CSR_IDX_W = 2;

   localparam int P_PROD_W = GAIN_W + 1 + ERR_W;
   localparam int I_PROD_W = GAIN_W + 1 + SUM_W;
   localparam int D_PROD_W = GAIN_W + 1 + DERIV_W;
   localparam int ACC_W    = I_PROD_W + 1;
   localparam int Q_W      = ACC_W - Q_SHIFT;

   localparam logic [GAIN_W-1:0] KP_RESET = 24'd1310720;
   localparam logic [GAIN_W-1:0] KI_RESET = 24'd197;
   localparam logic [GAIN_W-1:0] KD_RESET = 24'd2621440;

   localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 8'sd100;
   localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -8'sd100;

   localparam logic [CSR_IDX_W-1:0] CSR_KP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD = 2'd2;

   typedef struct packed {
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
      logic [GAIN_W-1:0] kd;
   } gains_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]   err;
      logic signed [DERIV_W-1:0] deriv;
      logic signed [SUM_W-1:0]   error_sum;
   } err_stage_type;

   typedef struct packed {
      logic signed [P_PROD_W-1:0] p_term;
      logic signed [I_PROD_W-1:0] i_term;
      logic signed [D_PROD_W-1:0] d_term;
   } prod_type;

endpackage

`default_nettype wire

// File: hw/rtl/pdc_csr.sv
`default_nettype none

module pdc_csr
   import pdc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [GAIN_W-1:0]    csr_wdata,
   output gains_type                 gains
);

   gains_type gains_ff;
   gains_type gains_in;

   assign csr_ready = 1'b1;
   assign gains     = gains_ff;

   always_comb begin
      gains_in = gains_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KP:  gains_in.kp = csr_wdata;
            CSR_KI:  gains_in.ki = csr_wdata;
            CSR_KD:  gains_in.kd = csr_wdata;
            default: gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.kp <= KP_RESET;
         gains_ff.ki <= KI_RESET;
         gains_ff.kd <= KD_RESET;
      end else begin
         gains_ff <= gains_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/pdc_err.sv
`default_nettype none

module pdc_err
   import pdc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [FIELD_W-1:0] setpoint,
   input  wire logic [FIELD_W-1:0] feedback,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output err_stage_type           out_data
);

`include "pid_drive_controller_assert.svh"

   logic                      valid_ff;
   logic                      valid_in;
   err_stage_type             data_ff;
   logic signed [ERR_W-1:0]   last_error_ff;
   logic signed [SUM_W-1:0]   error_sum_ff;
   logic                      load;
   logic signed [FIELD_W:0]   diff;
   logic signed [ERR_W-1:0]   err_in;
   logic signed [SUM_W:0]     sum_wide;
   logic signed [SUM_W-1:0]   error_sum_in;
   logic signed [DERIV_W-1:0] deriv_in;

   assign in_ready  = !valid_ff || out_ready;
   assign load      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign valid_in  = load || (valid_ff && !out_ready);

   // error saturates to 16 bits
   assign diff = $signed({1'b0, setpoint}) - $signed({1'b0, feedback});
   always_comb begin
      if (diff > $signed({2'b00, {(ERR_W-1){1'b1}}})) begin
         err_in = {1'b0, {(ERR_W-1){1'b1}}};
      end else if (diff < $signed({2'b11, {(ERR_W-1){1'b0}}})) begin
         err_in = {1'b1, {(ERR_W-1){1'b0}}};
      end else begin
         err_in = diff[ERR_W-1:0];
      end
   end

   // integral takes the previous error, saturating
   assign sum_wide = {error_sum_ff[SUM_W-1], error_sum_ff}
                   + {{(SUM_W+1-ERR_W){last_error_ff[ERR_W-1]}}, last_error_ff};
   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         error_sum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         error_sum_in = sum_wide[SUM_W-1:0];
      end
   end

   assign deriv_in = {err_in[ERR_W-1], err_in} - {last_error_ff[ERR_W-1], last_error_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         last_error_ff <= '0;
         error_sum_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            last_error_ff <= err_in;
            error_sum_ff  <= error_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff.err       <= err_in;
         data_ff.deriv     <= deriv_in;
         data_ff.error_sum <= error_sum_in;
      end
   end

   `PDC_ASSERT(a_sum_no_neg_wrap, clock, reset,
      (load && !error_sum_ff[SUM_W-1] && !last_error_ff[ERR_W-1]) |=> !error_sum_ff[SUM_W-1],
      "integral wrapped negative")
   `PDC_ASSERT(a_sum_no_pos_wrap, clock, reset,
      (load && error_sum_ff[SUM_W-1] && last_error_ff[ERR_W-1]) |=> error_sum_ff[SUM_W-1],
      "integral wrapped positive")
   `PDC_ASSERT(a_state_matches_stage, clock, reset,
      load |=> (data_ff.err == last_error_ff && data_ff.error_sum == error_sum_ff),
      "stored state differs from stage output")

endmodule

`default_nettype wire

// File: hw/rtl/pdc_mul.sv
`default_nettype none

module pdc_mul
   import pdc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire gains_type     gains,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire err_stage_type in_data,
   output logic               out_valid,
   input  wire logic          out_ready,
   output prod_type           out_data
);

   logic     valid_ff;
   logic     valid_in;
   logic     load;
   prod_type data_ff;
   prod_type data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign load      = in_valid && in_ready;
   assign valid_in  = load || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   assign data_in.p_term = $signed({1'b0, gains.kp}) * in_data.err;
   assign data_in.i_term = $signed({1'b0, gains.ki}) * in_data.error_sum;
   assign data_in.d_term = $signed({1'b0, gains.kd}) * in_data.deriv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/pdc_out.sv
`default_nettype none

module pdc_out
   import pdc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire prod_type             in_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [DRIVE_W-1:0] rsp_drive
);

   logic                      acc_valid_ff;
   logic                      acc_valid_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic                      acc_load;
   logic                      drv_valid_ff;
   logic                      drv_valid_in;
   logic signed [DRIVE_W-1:0] drive_ff;
   logic signed [DRIVE_W-1:0] drive_in;
   logic                      drv_ready;
   logic                      drv_load;
   logic signed [Q_W-1:0]     q_floor;
   logic signed [Q_W-1:0]     q_trunc;
   logic                      round_up;

   assign drv_ready    = !drv_valid_ff || !rsp_stall;
   assign drv_load     = acc_valid_ff && drv_ready;
   assign in_ready     = !acc_valid_ff || drv_ready;
   assign acc_load     = in_valid && in_ready;
   assign acc_valid_in = acc_load || (acc_valid_ff && !drv_ready);
   assign drv_valid_in = drv_load || (drv_valid_ff && rsp_stall);
   assign rsp_valid    = drv_valid_ff;
   assign rsp_drive    = drive_ff;

   assign acc_in = ACC_W'(in_data.p_term) + ACC_W'(in_data.i_term)
                 + ACC_W'(in_data.d_term);

   // divide by 2^16, rounding toward zero
   assign q_floor  = acc_ff[ACC_W-1:Q_SHIFT];
   assign round_up = acc_ff[ACC_W-1] && (acc_ff[Q_SHIFT-1:0] != '0);
   assign q_trunc  = q_floor + $signed({{(Q_W-1){1'b0}}, round_up});

   always_comb begin
      if (q_trunc > Q_W'(DRIVE_MAX)) begin
         drive_in = DRIVE_MAX;
      end else if (q_trunc < Q_W'(DRIVE_MIN)) begin
         drive_in = DRIVE_MIN;
      end else begin
         drive_in = q_trunc[DRIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
         drv_valid_ff <= 1'b0;
      end else begin
         acc_valid_ff <= acc_valid_in;
         drv_valid_ff <= drv_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_load) begin
         acc_ff <= acc_in;
      end
      if (drv_load) begin
         drive_ff <= drive_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/pid_drive_controller.sv
// channel  | direction | handshake              | payload
// req      | in        | req_valid / req_stall  | req_setpoint, req_feedback
// rsp      | out       | rsp_valid / rsp_stall  | rsp_drive
// csr      | in        | csr_valid / csr_ready  | csr_index, csr_wdata
//
// One transfer per cycle on req and rsp while rsp_stall is low.
// Stages: input register, error/integral, three multiplies, sum, clamp.
// Error and integral state update on each load, so items follow back to back.
// Each stage holds its item while the next is full; bubbles are squeezed out.
// Reset is synchronous: gains return to defaults, state and valids clear.
`default_nettype none

module pid_drive_controller
   import pdc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [FIELD_W-1:0]   req_setpoint,
   input  wire logic [FIELD_W-1:0]   req_feedback,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [DRIVE_W-1:0] rsp_drive,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [GAIN_W-1:0]    csr_wdata
);

   gains_type            gains;
   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [FIELD_W-1:0]   setpoint_ff;
   logic [FIELD_W-1:0]   feedback_ff;
   logic                 in_ready;
   logic                 in_load;
   logic                 err_ready;
   logic                 err_valid;
   err_stage_type        err_data;
   logic                 mul_ready;
   logic                 mul_valid;
   prod_type             mul_data;
   logic                 out_ready;

   assign in_ready    = !in_valid_ff || err_ready;
   assign req_stall   = !in_ready;
   assign in_load     = req_valid && in_ready;
   assign in_valid_in = in_load || (in_valid_ff && !err_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         setpoint_ff <= req_setpoint;
         feedback_ff <= req_feedback;
      end
   end

   pdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .gains     (gains)
   );

   pdc_err u_err (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_ready  (err_ready),
      .setpoint  (setpoint_ff),
      .feedback  (feedback_ff),
      .out_valid (err_valid),
      .out_ready (mul_ready),
      .out_data  (err_data)
   );

   pdc_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .gains     (gains),
      .in_valid  (err_valid),
      .in_ready  (mul_ready),
      .in_data   (err_data),
      .out_valid (mul_valid),
      .out_ready (out_ready),
      .out_data  (mul_data)
   );

   pdc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (out_ready),
      .in_data   (mul_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_drive (rsp_drive)
   );

endmodule

`default_nettype wire
